// ===== hdl/midi_message_framer_top_defines.svh =====
// assertion macros for the midi message framer
// used by the modules that carry concurrent checks; expects clk_i and rst_ni in scope
`ifndef MIDI_MESSAGE_FRAMER_TOP_DEFINES_SVH
`define MIDI_MESSAGE_FRAMER_TOP_DEFINES_SVH

// property must hold at every clock edge outside reset
`define MMF_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen outside reset
`define MMF_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ===== hdl/mmf_pkg.sv =====
// shared types, status codes and message length decode for the midi message framer
// no dependencies
package mmf_pkg;

  // status byte codes
  localparam logic [7:0] ST_SYSEX  = 8'hF0;
  localparam logic [7:0] ST_EOX    = 8'hF7;
  localparam logic [7:0] ST_RT_MIN = 8'hF8;
  localparam logic [7:0] ST_SYS    = 8'hF0;

  // default sysex buffer depth
  localparam int SYSEX_LIMIT_DEF = 63;

  // one byte offered to the output stage
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic       last;
  } emit_t;

  // message length in bytes, status included
  function automatic logic [1:0] msg_len(input logic [7:0] s);
    logic [1:0] len;
    len = 2'd3;
    case (s) inside
      [8'hF8:8'hFF]:              len = 2'd1;
      8'hF1, 8'hF3, 8'hF5:        len = 2'd2;
      8'hF2:                      len = 2'd3;
      8'hF4, 8'hF6, 8'hF7:        len = 2'd1;
      [8'hC0:8'hDF]:              len = 2'd2;
      default:                    len = 2'd3;
    endcase
    return len;
  endfunction

endpackage

// ===== hdl/midi_message_framer_top.sv =====
// Raw MIDI bytes enter one per request on the input channel; complete messages leave
// one byte per request with last_byte_o on the final byte. Real-time bytes pass at once,
// channel messages honour running status and SysEx is buffered (up to SYSEX_LIMIT bytes,
// F0 included) and released whole on F7. A byte that completes nothing is taken with ready
// staying high, so such bytes can follow back to back. A byte that completes a message holds
// ready low until its bytes are emitted: one for real-time, one to three for other messages
// and fill + 1 for a SysEx flush (up to SYSEX_LIMIT + 1), waiting on the output register and
// paced by the single read port of the SysEx buffer and its shared step counter. The output
// register lets a new byte be accepted while the last result still waits for the consumer.
// depends on mmf_pkg and mmf_ctrl
module midi_message_framer_top
  import mmf_pkg::*;
#(
  parameter int SYSEX_LIMIT = SYSEX_LIMIT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_byte_o
);

  emit_t      emit;
  logic       slot_free;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q;
  logic       out_last_q;

  assign slot_free = !out_valid_q || out_ready_i;

  mmf_ctrl #(
    .SYSEX_LIMIT (SYSEX_LIMIT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .slot_free_i (slot_free),
    .emit_o      (emit)
  );

  // output register valid
  always_comb begin
    if (emit.valid && slot_free) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (emit.valid && slot_free) begin
      out_byte_q <= emit.data;
      out_last_q <= emit.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign last_byte_o = out_last_q;

endmodule

// ===== hdl/mmf_step_unit.sv =====
// shared increment and compare unit for the sysex counters
// depends on nothing; used by mmf_ctrl
module mmf_step_unit #(
  parameter int W = 7
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] bound_i,
  output logic [W-1:0] sum_o,
  output logic         lt_o
);

  // next count and room check
  assign sum_o = a_i + W'(1);
  assign lt_o  = (a_i < bound_i);

endmodule

// ===== hdl/mmf_sysex_mem.sv =====
// sysex byte buffer, one write port and one registered read port
// depends on nothing; used by mmf_ctrl
module mmf_sysex_mem #(
  parameter int DEPTH  = 63,
  parameter int ADDR_W = 6
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [7:0]        wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [7:0]        rd_data_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ===== hdl/mmf_ctrl.sv =====
// parser state and emission sequencer of the midi message framer
// depends on mmf_pkg, mmf_step_unit, mmf_sysex_mem and the assertion macro header
`include "midi_message_framer_top_defines.svh"

module mmf_ctrl
  import mmf_pkg::*;
#(
  parameter int SYSEX_LIMIT = SYSEX_LIMIT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       slot_free_i,
  output emit_t      emit_o
);

  localparam int FILL_W = $clog2(SYSEX_LIMIT + 1);
  localparam int ADDR_W = $clog2(SYSEX_LIMIT);
  localparam logic [FILL_W-1:0] LIMIT_C = FILL_W'(SYSEX_LIMIT);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PEND = 4'b0010,
    S_SX   = 4'b0100,
    S_ONE  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [7:0]        rs_q, rs_d;
  logic [1:0]        have_q, have_d;
  logic [1:0]        want_q, want_d;
  logic              in_sx_q, in_sx_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] nxt_q, nxt_d;
  logic [1:0]        pidx_q, pidx_d;
  logic [7:0]        hold_q, hold_d;
  logic [7:0]        pend_q [3];
  logic [7:0]        pend_d [3];

  logic              acc;
  logic              take;
  logic [FILL_W-1:0] su_a, su_bound, su_sum;
  logic              su_lt;
  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [7:0]        rd_data;
  logic              handled;
  logic [1:0]        have_eff, want_eff, have_new;
  logic              pend_last;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i & in_ready_o;
  assign pend_last  = ((pidx_q + 2'd1) == want_q);

  // shared counter: read pointer during flush, fill pointer otherwise
  always_comb begin
    if (state_q == S_SX) begin
      su_a     = nxt_q;
      su_bound = fill_q;
    end else begin
      su_a     = fill_q;
      su_bound = LIMIT_C;
    end
  end

  mmf_step_unit #(
    .W (FILL_W)
  ) u_step (
    .a_i     (su_a),
    .bound_i (su_bound),
    .sum_o   (su_sum),
    .lt_o    (su_lt)
  );

  mmf_sysex_mem #(
    .DEPTH  (SYSEX_LIMIT),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_byte_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // byte offered to the output stage
  always_comb begin
    emit_o = '0;
    case (state_q)
      S_PEND: begin
        emit_o.valid = 1'b1;
        emit_o.data  = pend_q[pidx_q];
        emit_o.last  = pend_last;
      end
      S_SX: begin
        emit_o.valid = 1'b1;
        emit_o.data  = rd_data;
        emit_o.last  = 1'b0;
      end
      S_ONE: begin
        emit_o.valid = 1'b1;
        emit_o.data  = hold_q;
        emit_o.last  = 1'b1;
      end
      default: emit_o = '0;
    endcase
  end

  assign take = emit_o.valid & slot_free_i;

  // request decode and sequencing
  always_comb begin
    state_d   = state_q;
    rs_d      = rs_q;
    have_d    = have_q;
    want_d    = want_q;
    in_sx_d   = in_sx_q;
    fill_d    = fill_q;
    nxt_d     = nxt_q;
    pidx_d    = pidx_q;
    hold_d    = hold_q;
    pend_d    = pend_q;
    wr_en     = 1'b0;
    wr_addr   = fill_q[ADDR_W-1:0];
    rd_en     = 1'b0;
    rd_addr   = '0;
    handled   = 1'b0;
    have_eff  = have_q;
    want_eff  = want_q;
    have_new  = have_q;

    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (in_byte_i >= ST_RT_MIN) begin
            // real-time byte goes straight out
            hold_d  = in_byte_i;
            state_d = S_ONE;
          end else begin
            if (in_sx_q) begin
              handled = 1'b1;
              if (in_byte_i == ST_EOX) begin
                // start the buffer flush at the first stored byte
                rd_en   = 1'b1;
                rd_addr = '0;
                nxt_d   = FILL_W'(1);
                in_sx_d = 1'b0;
                state_d = S_SX;
              end else if (!in_byte_i[7]) begin
                if (su_lt) begin
                  wr_en  = 1'b1;
                  fill_d = su_sum;
                end
              end else begin
                // other status aborts the sysex and is handled below
                in_sx_d = 1'b0;
                fill_d  = '0;
                handled = 1'b0;
              end
            end
            if (!handled) begin
              if (in_byte_i == ST_SYSEX) begin
                in_sx_d = 1'b1;
                wr_en   = 1'b1;
                wr_addr = '0;
                fill_d  = FILL_W'(1);
                rs_d    = '0;
                have_d  = 2'd0;
              end else if (in_byte_i[7]) begin
                rs_d      = (in_byte_i < ST_SYS) ? in_byte_i : 8'h00;
                pend_d[0] = in_byte_i;
                want_d    = msg_len(in_byte_i);
                if (msg_len(in_byte_i) == 2'd1) begin
                  have_d  = 2'd0;
                  pidx_d  = 2'd0;
                  state_d = S_PEND;
                end else begin
                  have_d  = 2'd1;
                end
              end else if (!((have_q == 2'd0) && (rs_q == 8'h00))) begin
                // data byte, reopen from running status when nothing is pending
                if (have_q == 2'd0) begin
                  pend_d[0] = rs_q;
                  have_eff  = 2'd1;
                  want_eff  = msg_len(rs_q);
                  want_d    = want_eff;
                end
                pend_d[have_eff] = in_byte_i;
                have_new         = have_eff + 2'd1;
                if (have_new >= want_eff) begin
                  have_d  = (rs_q != 8'h00) ? 2'd1 : 2'd0;
                  pidx_d  = 2'd0;
                  state_d = S_PEND;
                end else begin
                  have_d  = have_new;
                end
              end
            end
          end
        end
      end
      S_PEND: begin
        if (take) begin
          if (pend_last) begin
            state_d = S_IDLE;
          end else begin
            pidx_d = pidx_q + 2'd1;
          end
        end
      end
      S_SX: begin
        if (take) begin
          if (su_lt) begin
            rd_en   = 1'b1;
            rd_addr = nxt_q[ADDR_W-1:0];
            nxt_d   = su_sum;
          end else begin
            hold_d  = ST_EOX;
            fill_d  = '0;
            state_d = S_ONE;
          end
        end
      end
      S_ONE: begin
        if (take) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rs_q    <= '0;
      have_q  <= '0;
      want_q  <= '0;
      in_sx_q <= 1'b0;
      fill_q  <= '0;
      pidx_q  <= '0;
    end else begin
      state_q <= state_d;
      rs_q    <= rs_d;
      have_q  <= have_d;
      want_q  <= want_d;
      in_sx_q <= in_sx_d;
      fill_q  <= fill_d;
      pidx_q  <= pidx_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    nxt_q  <= nxt_d;
    hold_q <= hold_d;
    pend_q <= pend_d;
  end

  `MMF_ASSERT(a_fill_bound, fill_q <= LIMIT_C, "sysex fill beyond buffer depth")
  `MMF_ASSERT(a_sysex_open, in_sx_q |-> (fill_q != '0), "open sysex with empty buffer")
  `MMF_ASSERT(a_have_bound, (have_q == 2'd0) || (have_q < want_q), "pending count past length")
  `MMF_NEVER(a_flush_open, (state_q == S_SX) && in_sx_q, "sysex flush while still open")
  `MMF_ASSERT(a_pend_len, (state_q == S_PEND) |-> (want_q != 2'd0), "flush of empty message")

endmodule

// ===== sim/mmf_stream_checker.sv =====
// status codes shared by the stimulus and the checker, plus the stream checker itself
// the checker predicts framed midi messages from accepted input bytes and compares results
// depends on mmf_pkg
package mmf_codes_pkg;

  localparam logic [7:0] NO_STATUS      = 8'h00;
  localparam logic [7:0] DATA_MAX       = 8'h7F;
  localparam logic [7:0] ST_NOTE_OFF    = 8'h80;
  localparam logic [7:0] ST_NOTE_ON     = 8'h90;
  localparam logic [7:0] ST_PROG        = 8'hC0;
  localparam logic [7:0] ST_CHAN_PRS    = 8'hD0;
  localparam logic [7:0] ST_PITCH       = 8'hE0;
  localparam logic [7:0] ST_CHAN_MAX    = 8'hEF;
  localparam logic [7:0] ST_MTC         = 8'hF1;
  localparam logic [7:0] ST_SONG_POS    = 8'hF2;
  localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
  localparam logic [7:0] ST_UNDEF_F4    = 8'hF4;
  localparam logic [7:0] ST_UNDEF_F5    = 8'hF5;
  localparam logic [7:0] ST_TUNE        = 8'hF6;
  localparam logic [7:0] ST_RT_UNDEF_F9 = 8'hF9;
  localparam logic [7:0] ST_RT_UNDEF_FD = 8'hFD;
  localparam logic [7:0] ST_RT_RESET    = 8'hFF;

endpackage

module mmf_stream_checker
  import mmf_pkg::*;
  import mmf_codes_pkg::*;
#(
  parameter int SYSEX_LIMIT = SYSEX_LIMIT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       last_byte_i,
  output int         mismatches_o,
  output int         outstanding_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } midi_out_t;

  // bytes of framed messages still owed by the block, oldest first
  midi_out_t due_q [$];
  midi_out_t head;

  // predictor state
  logic [7:0] run_status;
  logic [7:0] part_buf [0:2];
  int         part_have;
  int         part_want;
  logic       in_sx;
  logic [7:0] sx_buf [0:SYSEX_LIMIT-1];
  int         sx_fill;

  int faults;
  int seen;

  // message length including the status byte
  function automatic int frame_len(input logic [7:0] s);
    int n;
    n = 3;
    if (s >= ST_RT_MIN || s == ST_UNDEF_F4 || s == ST_TUNE || s == ST_EOX) begin
      n = 1;
    end else if (s == ST_MTC || s == ST_SONG_SEL || s == ST_UNDEF_F5) begin
      n = 2;
    end else if (s == ST_SONG_POS) begin
      n = 3;
    end else if (s[7:4] == ST_PROG[7:4] || s[7:4] == ST_CHAN_PRS[7:4]) begin
      n = 2;
    end
    return n;
  endfunction

  function automatic void queue_byte(input logic [7:0] d, input logic l);
    midi_out_t e;
    e.data = d;
    e.last = l;
    due_q.insert(due_q.size(), e);
  endfunction

  function automatic void emit_partial();
    int k;
    for (k = 0; k < part_want; k++) queue_byte(part_buf[k], k + 1 == part_want);
  endfunction

  // advance the framer state by one raw byte and queue whatever it completes
  function automatic void frame_midi_byte(input logic [7:0] b);
    int  k;
    logic done;
    done = 1'b0;
    if (b >= ST_RT_MIN) begin
      // real-time goes straight out, state untouched
      queue_byte(b, 1'b1);
      done = 1'b1;
    end else if (in_sx) begin
      if (b == ST_EOX) begin
        for (k = 0; k < sx_fill; k++) queue_byte(sx_buf[k], 1'b0);
        queue_byte(b, 1'b1);
        sx_fill = 0;
        in_sx   = 1'b0;
        done    = 1'b1;
      end else if (!b[7]) begin
        // data past the buffer limit is dropped
        if (sx_fill < SYSEX_LIMIT) begin
          sx_buf[sx_fill] = b;
          sx_fill++;
        end
        done = 1'b1;
      end else begin
        // another status aborts the sysex and is then handled normally
        sx_fill = 0;
        in_sx   = 1'b0;
      end
    end
    if (!done) begin
      if (b == ST_SYSEX) begin
        in_sx      = 1'b1;
        sx_buf[0]  = b;
        sx_fill    = 1;
        run_status = NO_STATUS;
        part_have  = 0;
      end else if (b[7]) begin
        run_status  = (b < ST_SYSEX) ? b : NO_STATUS;
        part_buf[0] = b;
        part_have   = 1;
        part_want   = frame_len(b);
        if (part_want == 1) begin
          emit_partial();
          part_have = 0;
        end
      end else if (part_have != 0 || run_status != NO_STATUS) begin
        // data byte, possibly starting a message under running status
        if (part_have == 0) begin
          part_buf[0] = run_status;
          part_have   = 1;
          part_want   = frame_len(run_status);
        end
        part_buf[part_have] = b;
        part_have++;
        if (part_have >= part_want) begin
          emit_partial();
          part_have = (run_status != NO_STATUS) ? 1 : 0;
        end
      end
    end
  endfunction

  function automatic void log_fault(input string what);
    faults++;
    if (faults <= 10) $display("%0t mismatch: %s", $time, what);
  endfunction

  // results are checked before the input of the same edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_status = NO_STATUS;
      part_have  = 0;
      part_want  = 0;
      in_sx      = 1'b0;
      sx_fill    = 0;
      faults     = 0;
      seen       = 0;
      due_q.delete();
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_q.size() == 0) begin
          log_fault($sformatf("result %0d byte %02h last %0b with nothing due",
                              seen, out_byte_i, last_byte_i));
        end else begin
          head = due_q.pop_front();
          if (head.data !== out_byte_i || head.last !== last_byte_i) begin
            log_fault($sformatf("result %0d expected %02h last %0b, got %02h last %0b",
                                seen, head.data, head.last, out_byte_i, last_byte_i));
          end
        end
        seen++;
      end
      if (in_valid_i && in_ready_i) frame_midi_byte(in_byte_i);
      mismatches_o  <= faults;
      outstanding_o <= due_q.size();
    end
  end

endmodule

// ===== sim/tb.sv =====
// top of the midi message framer testbench: clock, reset, byte stimulus and verdict
// depends on mmf_pkg, mmf_codes_pkg, mmf_stream_checker and midi_message_framer_top
module tb
  import mmf_pkg::*;
  import mmf_codes_pkg::*;
();

  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG    = 4000;
  localparam int SETTLE      = 80;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] in_byte_i   = 8'h00;
  logic       out_ready_i = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       last_byte_o;

  int   mismatches;
  int   outstanding;
  int   offered     = 0;
  int   sx_frames   = 0;
  int   sx_long     = 0;
  int   bytes_out   = 0;
  int   msgs_out    = 0;
  int   idle_cycles = 0;
  logic calm        = 1'b0;
  logic long_sent   = 1'b0;
  logic burst_phase = 1'b0;
  logic hold_done   = 1'b0;

  midi_message_framer_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_byte_o (last_byte_o)
  );

  mmf_stream_checker chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_byte_i     (in_byte_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_byte_i    (out_byte_o),
    .last_byte_i   (last_byte_o),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // idle stretch length: mostly short, now and then long
  function automatic int idle_len();
    int r;
    int n;
    r = $urandom_range(0, 99);
    if (r < 55) n = 0;
    else if (r < 85) n = $urandom_range(1, 3);
    else if (r < 96) n = $urandom_range(4, 12);
    else n = $urandom_range(20, 60);
    return n;
  endfunction

  // one request on the input channel, after an optional idle gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    offered++;
  endtask

  // data byte with the odd real-time byte slipped in front
  task automatic send_data(input logic [7:0] b);
    if ($urandom_range(0, 11) == 0) send_byte(8'($urandom_range(ST_RT_MIN, ST_RT_RESET)));
    send_byte(b);
  endtask

  task automatic send_sysex(input int n);
    send_byte(ST_SYSEX);
    repeat (n) send_data(8'($urandom_range(0, DATA_MAX)));
    send_byte(ST_EOX);
    sx_frames++;
  endtask

  // one randomly chosen message shape, mostly well formed
  task automatic send_random_msg();
    int kind;
    int n;
    logic [7:0] st;
    logic big_one;
    kind = $urandom_range(0, 99);
    if (!long_sent && offered >= 60) kind = 55;
    if (kind < 35) begin
      // channel message then a few running status groups
      st = 8'($urandom_range(ST_NOTE_OFF, ST_CHAN_MAX));
      n  = (st[7:4] == ST_PROG[7:4] || st[7:4] == ST_CHAN_PRS[7:4]) ? 1 : 2;
      send_byte(st);
      repeat ($urandom_range(1, 4)) begin
        repeat (n) send_data(8'($urandom_range(0, DATA_MAX)));
      end
    end else if (kind < 50) begin
      // system common, sometimes with a stray data byte after it
      case ($urandom_range(0, 6))
        0: begin st = ST_MTC;      n = 1; end
        1: begin st = ST_SONG_POS; n = 2; end
        2: begin st = ST_SONG_SEL; n = 1; end
        3: begin st = ST_UNDEF_F5; n = 1; end
        4: begin st = ST_UNDEF_F4; n = 0; end
        5: begin st = ST_TUNE;     n = 0; end
        default: begin st = ST_EOX; n = 0; end
      endcase
      send_byte(st);
      repeat (n + $urandom_range(0, 1)) send_data(8'($urandom_range(0, DATA_MAX)));
    end else if (kind < 70) begin
      big_one = (!long_sent && offered >= 50) || ($urandom_range(0, 9) == 0);
      n = big_one ? $urandom_range(SYSEX_LIMIT_DEF + 1, SYSEX_LIMIT_DEF + 9)
                  : $urandom_range(0, 6);
      send_sysex(n);
      if (big_one) begin
        long_sent = 1'b1;
        sx_long++;
      end
    end else if (kind < 78) begin
      // sysex cut short by another status
      send_byte(ST_SYSEX);
      repeat ($urandom_range(0, 4)) send_data(8'($urandom_range(0, DATA_MAX)));
      send_byte(8'($urandom_range(ST_NOTE_OFF, ST_TUNE)));
      repeat ($urandom_range(0, 2)) send_data(8'($urandom_range(0, DATA_MAX)));
    end else if (kind < 92) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(8'($urandom_range(ST_RT_MIN, ST_RT_RESET)));
    end
  endtask

  // stop offering and wait for every owed byte
  task automatic wait_all_due();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // stimulus
  initial begin : stimulus
    logic [7:0] opening [$];
    opening = '{ST_RT_RESET, DATA_MAX,
                ST_NOTE_ON, 8'h3C, 8'h00, 8'h00, DATA_MAX,
                ST_PROG | 8'h05, 8'h05,
                ST_PITCH | 8'h0F, 8'h01, ST_RT_UNDEF_F9, DATA_MAX,
                ST_MTC, 8'h10, 8'h11,
                ST_TUNE, ST_EOX,
                ST_SYSEX, 8'h7E, ST_RT_UNDEF_FD, 8'h01, ST_EOX,
                ST_SYSEX, 8'h01, ST_NOTE_OFF, 8'h40, DATA_MAX};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed opening: field extremes and each corner of the framing rules
    foreach (opening[k]) send_byte(opening[k]);

    while (offered < 130) begin
      if ($urandom_range(0, 9) == 0) calm = !calm;
      send_random_msg();
    end

    // sender pause until the block has handed everything back
    wait_all_due();

    // back to back requests while the receiver holds off
    calm        = 1'b1;
    burst_phase <= 1'b1;
    send_sysex(40);
    repeat (8) send_byte(8'($urandom_range(ST_RT_MIN, ST_RT_RESET)));
    send_byte(ST_NOTE_ON);
    send_data(8'($urandom_range(0, DATA_MAX)));
    send_data(8'($urandom_range(0, DATA_MAX)));
    burst_phase <= 1'b0;
    calm        = 1'b0;

    while (offered < 220) begin
      if ($urandom_range(0, 9) == 0) calm = !calm;
      send_random_msg();
    end

    wait_all_due();
    repeat (SETTLE) @(posedge clk_i);

    $display("offered %0d bytes including %0d sysex frames, %0d of them past the buffer limit",
             offered, sx_frames, sx_long);
    $display("took back %0d bytes in %0d messages, receiver held off once for %0d cycles",
             bytes_out, msgs_out, HOLD_CYCLES);
    if (mismatches == 0 && outstanding == 0) begin
      $display("midi_message_framer_top verification clean");
    end else begin
      $display("midi_message_framer_top verification failed");
    end
    $finish;
  end

  // receiver: random ready with one long hold-off during the burst
  initial begin : consumer
    int run;
    int stall;
    @(posedge rst_ni);
    forever begin
      if (burst_phase && !hold_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      out_ready_i <= 1'b1;
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 8);
      do begin
        @(posedge clk_i);
        run--;
      end while (run > 0 && !(burst_phase && !hold_done));
      stall = (burst_phase && !hold_done) ? 0 : idle_len();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // result counts and watchdog on cycles with no request moving
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        bytes_out <= bytes_out + 1;
        if (last_byte_o) msgs_out <= msgs_out + 1;
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no request moved for %0d cycles", WATCHDOG);
        $display("midi_message_framer_top verification failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
